@@ rtl/fphal_pkg.sv @@
package fphal_pkg;

	localparam int ACTION_W = 2;
	localparam int AMOUNT_W = 16;
	localparam int STATUS_W = 3;
	localparam int INDEX_W  = 4;
	localparam int LEFT_W   = 16;
	localparam int TOTAL_W  = 20;
	localparam int MODE_W   = 2;
	localparam int PADDR_W  = 2;
	localparam int PDATA_W  = 32;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	localparam logic [PADDR_W-1:0] REG_FIT_MODE = 2'd0;

	localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_REQ    = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_REPORT = 2'd3;

	localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_CLEARED  = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_ADDED    = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_ALLOC    = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_NOFIT    = 3'd4;
	localparam logic [STATUS_W-1:0] STAT_REJECTED = 3'd5;
	localparam logic [STATUS_W-1:0] STAT_RPT_OK   = 3'd6;
	localparam logic [STATUS_W-1:0] STAT_RPT_FRAG = 3'd7;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_RESULT
	} st_t;

endpackage

@@ rtl/fphal_req_if.sv @@
interface fphal_req_if import fphal_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [AMOUNT_W-1:0] amount;

	modport source (output valid, action, amount, input ready);
	modport sink (input valid, action, amount, output ready);
endinterface

@@ rtl/fphal_res_if.sv @@
interface fphal_res_if import fphal_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [INDEX_W-1:0]  hole_index;
	logic [LEFT_W-1:0]   hole_left;
	logic [TOTAL_W-1:0]  free_total;

	modport source (output valid, status, hole_index, hole_left, free_total, input ready);
	modport sink (input valid, status, hole_index, hole_left, free_total, output ready);
endinterface

@@ rtl/fphal_ram.sv @@
module fphal_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ rtl/fit_policy_hole_allocator_unit.sv @@
// Hole allocator: first, best or worst fit over a table of free holes.
// A scanning request reads one slot per cycle, then compares, updates the chosen
// hole and stages its result beat; any other item is staged directly.
// One item is handled at a time, and the next item is taken while the result
// beat waits, held off only by a stalled output.
// Async active-low reset empties the table, clears stop and free total, first fit.
module fit_policy_hole_allocator_unit import fphal_pkg::*; #(
	parameter int HOLE_SLOTS = 16,
	parameter int SIZE_BITS  = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	fphal_req_if.sink          req,
	fphal_res_if.source        res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int ADDR_W  = (HOLE_SLOTS > 1) ? $clog2(HOLE_SLOTS) : 1;
	localparam int COUNT_W = $clog2(HOLE_SLOTS + 1);
	localparam int CMP_W   = (SIZE_BITS > AMOUNT_W) ? SIZE_BITS : AMOUNT_W;
	localparam int SUM_W   = ((SIZE_BITS > TOTAL_W) ? SIZE_BITS : TOTAL_W) + 1;

	st_t                 state_q, state_nxt;
	logic [MODE_W-1:0]   fit_mode_q;
	logic [COUNT_W-1:0]  hole_count_q;
	logic [TOTAL_W-1:0]  free_sum_q;
	logic                stopped_q;
	logic [AMOUNT_W-1:0] need_q;
	logic [COUNT_W-1:0]  rd_idx_q;
	logic                cmp_vld_s1;
	logic [ADDR_W-1:0]   cmp_idx_s1;
	logic                pick_vld_q;
	logic [ADDR_W-1:0]   pick_idx_q;
	logic [SIZE_BITS-1:0] pick_val_q;

	logic [STATUS_W-1:0] rs_status_q;
	logic [INDEX_W-1:0]  rs_index_q;
	logic [LEFT_W-1:0]   rs_left_q;
	logic [TOTAL_W-1:0]  rs_total_q;

	logic                out_vld_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [INDEX_W-1:0]  out_index_q;
	logic [LEFT_W-1:0]   out_left_q;
	logic [TOTAL_W-1:0]  out_total_q;

	logic                in_ready, acc, rd_en, scan_done, out_load, go_scan;
	logic                cfg_wr, has_room, fits, take, fit_ok;
	logic [SIZE_BITS-1:0] add_size, rd_data;
	logic [SUM_W-1:0]    sum_add;
	logic [TOTAL_W-1:0]  sum_added, sum_taken;
	logic [CMP_W-1:0]    h_ext, need_ext, pick_ext, diff;
	logic                wr_en;
	logic [ADDR_W-1:0]   wr_addr;
	logic [SIZE_BITS-1:0] wr_data;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == REG_FIT_MODE);
	assign prdata = (paddr == REG_FIT_MODE) ? PDATA_W'(fit_mode_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q <= MODE_FIRST;
		end else if (cfg_wr) begin
			fit_mode_q <= pwdata[MODE_W-1:0];
		end
	end

	// datapath helpers
	assign acc       = req.valid && in_ready;
	assign has_room  = hole_count_q < COUNT_W'(HOLE_SLOTS);
	assign add_size  = SIZE_BITS'(req.amount);
	assign sum_add   = SUM_W'(free_sum_q) + SUM_W'(add_size);
	assign sum_added = (sum_add > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(sum_add);
	assign go_scan   = req.action == ACT_REQ && !stopped_q && hole_count_q != '0;

	assign need_ext  = CMP_W'(need_q);
	assign h_ext     = CMP_W'(rd_data);
	assign pick_ext  = CMP_W'(pick_val_q);
	assign fits      = h_ext >= need_ext;
	assign fit_ok    = pick_vld_q && (pick_ext >= need_ext);
	assign diff      = pick_ext - need_ext;
	assign sum_taken = (free_sum_q > TOTAL_W'(need_q)) ? free_sum_q - TOTAL_W'(need_q) : '0;

	always_comb begin
		unique case (fit_mode_q)
			MODE_BEST: begin
				take = fits && (!pick_vld_q || h_ext < pick_ext);
			end
			MODE_WORST: begin
				take = !pick_vld_q || h_ext > pick_ext;
			end
			default: begin
				take = fits && !pick_vld_q;
			end
		endcase
	end

	// sequencer
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					state_nxt = go_scan ? ST_SCAN : ST_RESULT;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_nxt = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				state_nxt = ST_RESULT;
			end
			ST_RESULT: begin
				if (out_load) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready  = state_q == ST_IDLE;
		rd_en     = state_q == ST_SCAN && rd_idx_q < hole_count_q;
		scan_done = state_q == ST_SCAN && !rd_en && !cmp_vld_s1;
		out_load  = state_q == ST_RESULT && (!out_vld_q || res.ready);
	end

	assign req.ready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// hole table
	always_comb begin
		if (state_q == ST_UPDATE) begin
			wr_en   = fit_ok;
			wr_addr = pick_idx_q;
			wr_data = SIZE_BITS'(diff);
		end else begin
			wr_en   = acc && req.action == ACT_ADD && has_room;
			wr_addr = ADDR_W'(hole_count_q);
			wr_data = add_size;
		end
	end

	fphal_ram #(
		.WIDTH (SIZE_BITS),
		.DEPTH (HOLE_SLOTS)
	) u_holes (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (ADDR_W'(rd_idx_q)),
		.rd_data (rd_data)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hole_count_q <= '0;
			free_sum_q   <= '0;
			stopped_q    <= 1'b0;
			rd_idx_q     <= '0;
			cmp_vld_s1   <= 1'b0;
			pick_vld_q   <= 1'b0;
		end else begin
			cmp_vld_s1 <= rd_en;
			if (acc) begin
				rd_idx_q   <= '0;
				pick_vld_q <= 1'b0;
				unique case (req.action)
					ACT_CLEAR: begin
						hole_count_q <= '0;
						free_sum_q   <= '0;
						stopped_q    <= 1'b0;
					end
					ACT_ADD: begin
						if (has_room) begin
							hole_count_q <= hole_count_q + 1'b1;
							free_sum_q   <= sum_added;
						end
					end
					ACT_REQ: begin
						if (hole_count_q == '0) begin
							stopped_q <= 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			if (rd_en) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (cmp_vld_s1 && take) begin
				pick_vld_q <= 1'b1;
			end
			if (state_q == ST_UPDATE) begin
				if (fit_ok) begin
					free_sum_q <= sum_taken;
				end else begin
					stopped_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			need_q <= req.amount;
		end
		if (rd_en) begin
			cmp_idx_s1 <= ADDR_W'(rd_idx_q);
		end
		if (cmp_vld_s1 && take) begin
			pick_idx_q <= cmp_idx_s1;
			pick_val_q <= rd_data;
		end
	end

	// result staging
	always_ff @(posedge clk) begin
		if (acc) begin
			rs_left_q <= '0;
			unique case (req.action)
				ACT_CLEAR: begin
					rs_status_q <= STAT_CLEARED;
					rs_index_q  <= '0;
					rs_total_q  <= '0;
				end
				ACT_ADD: begin
					if (has_room) begin
						rs_status_q <= STAT_ADDED;
						rs_index_q  <= INDEX_W'(hole_count_q);
						rs_total_q  <= sum_added;
					end else begin
						rs_status_q <= STAT_FULL;
						rs_index_q  <= '0;
						rs_total_q  <= free_sum_q;
					end
				end
				ACT_REQ: begin
					rs_status_q <= stopped_q ? STAT_REJECTED : STAT_NOFIT;
					rs_index_q  <= '0;
					rs_total_q  <= free_sum_q;
				end
				ACT_REPORT: begin
					rs_status_q <= stopped_q ? STAT_RPT_FRAG : STAT_RPT_OK;
					rs_index_q  <= '0;
					rs_total_q  <= free_sum_q;
				end
				default: begin
					rs_status_q <= STAT_RPT_OK;
					rs_index_q  <= '0;
					rs_total_q  <= free_sum_q;
				end
			endcase
		end else if (state_q == ST_UPDATE) begin
			if (fit_ok) begin
				rs_status_q <= STAT_ALLOC;
				rs_index_q  <= INDEX_W'(pick_idx_q);
				rs_left_q   <= LEFT_W'(diff);
				rs_total_q  <= sum_taken;
			end else begin
				rs_status_q <= STAT_NOFIT;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (res.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= rs_status_q;
			out_index_q  <= rs_index_q;
			out_left_q   <= rs_left_q;
			out_total_q  <= rs_total_q;
		end
	end

	assign res.valid      = out_vld_q;
	assign res.status     = out_status_q;
	assign res.hole_index = out_index_q;
	assign res.hole_left  = out_left_q;
	assign res.free_total = out_total_q;

	// checks
	a_scan_not_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !stopped_q)
		else $error("scan running while stopped");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hole_count_q <= COUNT_W'(HOLE_SLOTS))
		else $error("hole count beyond table");

	a_pick_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE && pick_vld_q) |-> (COUNT_W'(pick_idx_q) < hole_count_q))
		else $error("chosen hole outside loaded slots");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req.action == ACT_CLEAR) |=> (hole_count_q == '0 && !stopped_q))
		else $error("clear left state behind");

endmodule
